// File: design/wwge_pkg.sv
// shared types and codes for the wireworld generation engine
package wwge_pkg;

   localparam int ACTION_W    = 2;
   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int CELL_W      = 2;
   localparam int KIND_W      = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   typedef logic [ACTION_W-1:0]    action_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [COL_W-1:0]       col_type;
   typedef logic [CELL_W-1:0]      cell_type;
   typedef logic [KIND_W-1:0]      kind_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam cell_type CELL_EMPTY = 2'd0;
   localparam cell_type CELL_HEAD  = 2'd1;
   localparam cell_type CELL_TAIL  = 2'd2;
   localparam cell_type CELL_COND  = 2'd3;

   localparam action_type ACT_WRITE = 2'd0;
   localparam action_type ACT_READ  = 2'd1;
   localparam action_type ACT_STEP  = 2'd2;

   localparam csr_index_type CSR_ACTIVE_ROWS = 1'b0;
   localparam csr_index_type CSR_ACTIVE_COLS = 1'b1;

   localparam csr_data_type ACTIVE_RESET = 7'd40;

endpackage

// File: design/wwge_if.sv
// request and response channel interfaces
interface wwge_req_if
   import wwge_pkg::*;
();
   logic       valid;
   logic       ready;
   action_type action;
   row_type    row;
   col_type    col;
   cell_type   cell_in;

   modport source (output valid, output action, output row, output col, output cell_in,
                   input ready);
   modport sink   (input valid, input action, input row, input col, input cell_in,
                   output ready);
endinterface

interface wwge_rsp_if
   import wwge_pkg::*;
();
   logic     valid;
   logic     ready;
   cell_type cell_out;
   kind_type done_kind;

   modport source (output valid, output cell_out, output done_kind, input ready);
   modport sink   (input valid, input cell_out, input done_kind, output ready);
endinterface

// File: design/wireworld_generation_engine.sv
// wireworld generation engine: row-wide grid memory and a per-cell rule unit
// write and read items pass through ST_WRMW or ST_RDATA to a registered result
// a generation covers the active rows, capped at MAX_ROWS, and answers straight from idle
// with no active row; the rule unit handles one cell per cycle, a row per pass
// one item at a time; req ready when idle and the previous result is taken
// reset clears the row valid bits at once (grid reads empty), sets both sizes to 40
module wireworld_generation_engine
   import wwge_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic          clock,
   input  logic          reset,
   wwge_req_if.sink      req,
   wwge_rsp_if.source    rsp,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   localparam int RIW = $clog2(MAX_ROWS);
   localparam int CIW = $clog2(MAX_COLS);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);
   localparam int RXW = RCW + 1;
   localparam int LW  = CELL_W * MAX_COLS;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_WRMW     = 3'd1;
   localparam logic [2:0] ST_RDATA    = 3'd2;
   localparam logic [2:0] ST_GLOADMID = 3'd3;
   localparam logic [2:0] ST_GLOADDN  = 3'd4;
   localparam logic [2:0] ST_GCELL    = 3'd5;
   localparam logic [2:0] ST_GWRITE   = 3'd6;

   function automatic logic [MAX_COLS-1:0] heads_of(input logic [LW-1:0] w,
                                                    input logic [MAX_COLS-1:0] mask);
      logic [MAX_COLS-1:0] h;
      for (int i = 0; i < MAX_COLS; i++) begin
         h[i] = (w[CELL_W*i +: CELL_W] == CELL_HEAD) && mask[i];
      end
      return h;
   endfunction

   // configuration
   csr_data_type rows_ff, cols_ff;
   logic [RCW-1:0] lim_rows;
   logic [CCW-1:0] lim_cols;
   logic [MAX_COLS-1:0] col_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ACTIVE_RESET;
         cols_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_ROWS: rows_ff <= csr_wdata;
            CSR_ACTIVE_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(rows_ff) > MAX_ROWS) lim_rows = RCW'(MAX_ROWS);
      else lim_rows = RCW'(rows_ff);
      if (int'(cols_ff) > MAX_COLS) lim_cols = CCW'(MAX_COLS);
      else lim_cols = CCW'(cols_ff);
      for (int i = 0; i < MAX_COLS; i++) begin
         col_mask[i] = i < int'(lim_cols);
      end
   end

   // grid memory, one row per word
   logic [LW-1:0] mem_ff [MAX_ROWS];
   logic [LW-1:0] rd_data_ff;
   logic          rd_valid_ff;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [RIW-1:0] rd_addr, wr_addr;
   logic [LW-1:0]  wr_data;
   logic           mem_we;
   logic [LW-1:0]  rd_row;

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[wr_addr] <= wr_data;
      rd_data_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

   // sequencer and rule unit
   logic [2:0]          state_ff, state_in;
   logic [RIW-1:0]      r_ff, r_in;
   logic [CIW-1:0]      c_ff, c_in;
   logic [MAX_COLS-1:0] up_h_ff, up_h_in, mid_h_ff, mid_h_in, dn_h_ff, dn_h_in;
   logic                lu_ff, lu_in, lm_ff, lm_in, ld_ff, ld_in;
   logic [LW-1:0]       mid_cell_ff, mid_cell_in, dn_cell_ff, dn_cell_in;
   logic [RIW-1:0]      op_row_ff, op_row_in;
   logic [CIW-1:0]      op_col_ff, op_col_in;
   cell_type            op_cell_ff, op_cell_in;
   logic                op_inside_ff, op_inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cell_type            rsp_cell_ff, rsp_cell_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic                req_fire;
   logic                dn_ok, last_row, right_ok;
   logic [3:0]          cnt;
   cell_type            v, nv;
   logic [LW-1:0]       patched;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.cell_out  = rsp_cell_ff;
   assign rsp.done_kind = rsp_kind_ff;

   always_comb begin
      dn_ok    = (RXW'(r_ff) + RXW'(1)) < RXW'(lim_rows);
      last_row = !dn_ok;
      right_ok = c_ff != CIW'(MAX_COLS - 1);
      cnt = 4'(lu_ff) + 4'(lm_ff) + 4'(ld_ff) + 4'(up_h_ff[0]) + 4'(dn_h_ff[0])
          + 4'(right_ok & up_h_ff[1]) + 4'(right_ok & mid_h_ff[1])
          + 4'(right_ok & dn_h_ff[1]);
      v = mid_cell_ff[CELL_W-1:0];
      case (v)
         CELL_HEAD: nv = CELL_TAIL;
         CELL_TAIL: nv = CELL_COND;
         CELL_COND: nv = (cnt == 4'd1 || cnt == 4'd2) ? CELL_HEAD : CELL_COND;
         default:   nv = CELL_EMPTY;
      endcase
      if (CCW'(c_ff) >= lim_cols) nv = v;
      patched = rd_row;
      patched[CELL_W*op_col_ff +: CELL_W] = op_cell_ff;
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      up_h_in      = up_h_ff;
      mid_h_in     = mid_h_ff;
      dn_h_in      = dn_h_ff;
      lu_in        = lu_ff;
      lm_in        = lm_ff;
      ld_in        = ld_ff;
      mid_cell_in  = mid_cell_ff;
      dn_cell_in   = dn_cell_ff;
      op_row_in    = op_row_ff;
      op_col_in    = op_col_ff;
      op_cell_in   = op_cell_ff;
      op_inside_in = op_inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_kind_in  = rsp_kind_ff;
      row_valid_in = row_valid_ff;
      rd_addr      = r_ff;
      wr_addr      = r_ff;
      wr_data      = mid_cell_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req.action == ACT_STEP) ? '0 : RIW'(req.row);
            if (req_fire) begin
               op_row_in    = RIW'(req.row);
               op_col_in    = CIW'(req.col);
               op_cell_in   = req.cell_in;
               op_inside_in = (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
               r_in         = '0;
               unique case (req.action)
                  ACT_WRITE: state_in = ST_WRMW;
                  ACT_READ:  state_in = ST_RDATA;
                  ACT_STEP: begin
                     if (lim_rows == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_cell_in  = CELL_EMPTY;
                        rsp_kind_in  = ACT_STEP;
                     end else begin
                        state_in = ST_GLOADMID;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WRMW: begin
            if (op_inside_ff) begin
               mem_we  = 1'b1;
               wr_addr = op_row_ff;
               wr_data = patched;
               row_valid_in[op_row_ff] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            rsp_cell_in  = CELL_EMPTY;
            rsp_kind_in  = ACT_WRITE;
            state_in     = ST_IDLE;
         end
         ST_RDATA: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = op_inside_ff ? rd_row[CELL_W*op_col_ff +: CELL_W] : CELL_EMPTY;
            rsp_kind_in  = ACT_READ;
            state_in     = ST_IDLE;
         end
         ST_GLOADMID: begin
            rd_addr     = RIW'(1);
            mid_cell_in = rd_row;
            mid_h_in    = heads_of(rd_row, col_mask);
            up_h_in     = '0;
            state_in    = ST_GLOADDN;
         end
         ST_GLOADDN: begin
            dn_cell_in = dn_ok ? rd_row : '0;
            dn_h_in    = dn_ok ? heads_of(rd_row, col_mask) : '0;
            c_in       = '0;
            lu_in      = 1'b0;
            lm_in      = 1'b0;
            ld_in      = 1'b0;
            state_in   = ST_GCELL;
         end
         ST_GCELL: begin
            lu_in       = up_h_ff[0];
            lm_in       = mid_h_ff[0];
            ld_in       = dn_h_ff[0];
            up_h_in     = {up_h_ff[0], up_h_ff[MAX_COLS-1:1]};
            mid_h_in    = {mid_h_ff[0], mid_h_ff[MAX_COLS-1:1]};
            dn_h_in     = {dn_h_ff[0], dn_h_ff[MAX_COLS-1:1]};
            mid_cell_in = {nv, mid_cell_ff[LW-1:CELL_W]};
            if (right_ok) c_in = c_ff + CIW'(1);
            else state_in = ST_GWRITE;
         end
         ST_GWRITE: begin
            mem_we      = 1'b1;
            wr_addr     = r_ff;
            wr_data     = mid_cell_ff;
            row_valid_in[r_ff] = 1'b1;
            rd_addr     = RIW'(int'(r_ff) + 2);
            up_h_in     = mid_h_ff;
            mid_h_in    = dn_h_ff;
            mid_cell_in = dn_cell_ff;
            if (last_row) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = CELL_EMPTY;
               rsp_kind_in  = ACT_STEP;
               state_in     = ST_IDLE;
            end else begin
               r_in     = r_ff + RIW'(1);
               state_in = ST_GLOADDN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      c_ff         <= c_in;
      up_h_ff      <= up_h_in;
      mid_h_ff     <= mid_h_in;
      dn_h_ff      <= dn_h_in;
      lu_ff        <= lu_in;
      lm_ff        <= lm_in;
      ld_ff        <= ld_in;
      mid_cell_ff  <= mid_cell_in;
      dn_cell_ff   <= dn_cell_in;
      op_row_ff    <= op_row_in;
      op_col_ff    <= op_col_in;
      op_cell_ff   <= op_cell_in;
      op_inside_ff <= op_inside_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

`ifndef SYNTHESIS
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.action == ACT_STEP && lim_rows != '0) |=> state_ff == ST_GLOADMID)
      else $error("generation did not start");

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCELL && right_ok)
         |=> (state_ff == ST_GCELL && c_ff == $past(c_ff) + CIW'(1)))
      else $error("column counter skipped");

   a_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == ST_IDLE)
      else $error("result raised outside idle");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCELL |-> RXW'(r_ff) < RXW'(lim_rows))
      else $error("generation row beyond active rows");
`endif

endmodule
